// ===== rtl/prio_sort_pkg.sv =====
// prio_sort_pkg: record type and field widths for the priority order sorter.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package prio_sort_pkg;

  localparam int ID_W    = 8;
  localparam int PRIO_W  = 8;
  localparam int BURST_W = 16;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } rec_t;

endpackage

// ===== rtl/priority_order_sorter_top.sv =====
// An insert keeps busy high while each stored record with a larger priority value is read,
// compared and shifted up one slot (one compare unit, one memory read port); a record that
// meets a full store is dropped and sets the drop flag.
// A drain emits one result per cycle from the registered read port once the batch_end
// record is placed or dropped. A new request is taken only while idle. The receiver cannot stall results.
// Reset (rst_n low, synchronous) empties the store and clears the drop flag; no clearing pass.
`timescale 1ns / 1ps

module priority_order_sorter_top
  import prio_sort_pkg::*;
#(
  parameter int MAX_RECORDS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [ID_W-1:0]    in_proc_id,
  input  logic [PRIO_W-1:0]  in_prio_value,
  input  logic [BURST_W-1:0] in_burst_time,
  input  logic               in_batch_end,
  output logic               out_strobe,
  output logic [ID_W-1:0]    out_proc_id,
  output logic [PRIO_W-1:0]  out_prio_value,
  output logic [BURST_W-1:0] out_burst_time,
  output logic               out_run_end,
  output logic               out_overflowed
);

  // AW addresses the store, CW counts up to a full store.
  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW = $clog2(MAX_RECORDS + 1);

  // Sequencer codes.
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a request
  localparam logic [2:0] S_LOAD  = 3'd1;  // full check, read the neighbor below pos
  localparam logic [2:0] S_CMP   = 3'd2;  // compare neighbor, shift it up or stop
  localparam logic [2:0] S_PLACE = 3'd3;  // write the new record at pos
  localparam logic [2:0] S_DRAIN = 3'd4;  // read out the store in order

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] pos_r, pos_nxt;      // insert slot, or drain index
  logic          drop_r, drop_nxt;
  logic          last_r, last_nxt;
  rec_t          new_r, new_nxt;

  // Result side: strobe and flags registered, fields come from the read register.
  logic emit_r, emit_nxt;
  logic out_end_r, out_end_nxt;
  logic out_ovf_r, out_ovf_nxt;

  // Record store: one write port, one registered read port.
  rec_t          mem [MAX_RECORDS];
  rec_t          rd_data_r;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  rec_t          wr_data;

  logic full;
  logic drain_done;

  assign full       = (count_r == CW'(MAX_RECORDS));
  assign drain_done = ((CW'(pos_r) + CW'(1)) == count_r);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    drop_nxt    = drop_r;
    last_nxt    = last_r;
    new_nxt     = new_r;
    emit_nxt    = 1'b0;
    out_end_nxt = out_end_r;
    out_ovf_nxt = out_ovf_r;
    rd_en       = 1'b0;
    rd_addr     = pos_r - AW'(1);
    wr_en       = 1'b0;
    wr_addr     = pos_r;
    wr_data     = new_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          new_nxt.id    = in_proc_id;
          new_nxt.prio  = in_prio_value;
          new_nxt.burst = in_burst_time;
          last_nxt      = in_batch_end;
          pos_nxt       = count_r[AW-1:0];
          state_nxt     = S_LOAD;
        end
      end
      S_LOAD: begin
        if (full) begin
          // no room: drop the record, still emit the run on batch end
          drop_nxt = 1'b1;
          if (last_r) begin
            pos_nxt   = '0;
            state_nxt = S_DRAIN;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (pos_r == '0) begin
          state_nxt = S_PLACE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        // strictly greater moves up, so equal priorities keep arrival order
        if (rd_data_r.prio > new_r.prio) begin
          wr_en     = 1'b1;
          wr_data   = rd_data_r;
          pos_nxt   = pos_r - AW'(1);
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        wr_en     = 1'b1;
        count_nxt = count_r + CW'(1);
        if (last_r) begin
          pos_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DRAIN: begin
        rd_en       = 1'b1;
        rd_addr     = pos_r;
        emit_nxt    = 1'b1;
        out_end_nxt = drain_done;
        out_ovf_nxt = drop_r;
        pos_nxt     = pos_r + AW'(1);
        if (drain_done) begin
          count_nxt = '0;
          drop_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      drop_r  <= 1'b0;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      emit_r  <= emit_nxt;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    last_r    <= last_nxt;
    new_r     <= new_nxt;
    out_end_r <= out_end_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // rd_data_r holds between reads, so the last result survives the return to idle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = emit_r;
  assign out_proc_id    = rd_data_r.id;
  assign out_prio_value = rd_data_r.prio;
  assign out_burst_time = rd_data_r.burst;
  assign out_run_end    = out_end_r;
  assign out_overflowed = out_ovf_r;

endmodule

// ===== rtl/prio_sort_chk.sv =====
// prio_sort_chk: port-level assertions for priority_order_sorter_top, and its bind.
// Depends on prio_sort_pkg for field widths.
`timescale 1ns / 1ps

module prio_sort_chk
  import prio_sort_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [PRIO_W-1:0]  out_prio_value,
  input logic               out_strobe,
  input logic               out_run_end,
  input logic               out_overflowed
);

  // every accepted request raises busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // a run is contiguous until its final result
  a_run_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_run_end |=> out_strobe)
    else $error("gap inside an output run");

  // nothing follows the final result directly
  a_run_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_run_end |=> !out_strobe)
    else $error("result after end of run");

  // results ascend in priority within a run
  a_ascend: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_run_end |=> out_prio_value >= $past(out_prio_value))
    else $error("run not in ascending priority order");

  // the overflow flag is constant across a run
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_run_end |=> out_overflowed == $past(out_overflowed))
    else $error("overflow flag changed inside a run");

endmodule

bind priority_order_sorter_top prio_sort_chk u_prio_sort_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_prio_value (out_prio_value),
  .out_strobe     (out_strobe),
  .out_run_end    (out_run_end),
  .out_overflowed (out_overflowed)
);
